// ----- rtl/core/tas_pkg.sv -----
`default_nettype none

package tas_pkg;

  localparam int MAX_CLASSES = 1024;
  localparam int TOP_K       = 5;
  localparam int PROB_BITS   = 16;
  localparam int IDX_W       = $clog2(MAX_CLASSES);
  localparam int CNT_W       = $clog2(MAX_CLASSES + 1);
  localparam int LABEL_W     = 11;
  localparam int TOTAL_W     = 32;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [PROB_BITS-1:0]      THRESH_RESET = PROB_BITS'(32768);
  localparam logic signed [LABEL_W-1:0] LABEL_REJECT = -LABEL_W'(2);
  localparam logic signed [LABEL_W-1:0] LABEL_NEG    = -LABEL_W'(1);
  localparam logic [CNT_W-1:0]          CNT_BINARY   = CNT_W'(2);
  localparam logic [CNT_W-1:0]          CNT_MAX      = CNT_W'(MAX_CLASSES);
  localparam logic [TOTAL_W-1:0]        TOTAL_MAX    = '1;

  typedef struct packed {
    logic                 valid;
    logic [PROB_BITS-1:0] prob;
    logic [IDX_W-1:0]     idx;
  } tas_entry_t;

  typedef tas_entry_t [TOP_K-1:0] tas_list_t;

  typedef struct packed {
    tas_list_t                  list;
    logic [CNT_W-1:0]           count;
    logic signed [LABEL_W-1:0]  label;
    logic                       clr;
  } tas_sample_t;

endpackage

`default_nettype wire

// ----- rtl/core/tas_front.sv -----
`default_nettype none

module tas_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [tas_pkg::PROB_BITS-1:0]      in_class_prob,
  input  wire logic                               in_class_last,
  input  wire logic signed [tas_pkg::LABEL_W-1:0] in_true_label,
  input  wire logic                               in_clear_totals,
  output logic                                    push_valid,
  output tas_pkg::tas_sample_t                    push_data,
  input  wire logic                               q_full
);
  import tas_pkg::*;

  tas_list_t        list_r, list_nxt, list_ins;
  logic [CNT_W-1:0] count_r, count_nxt, count_inc;
  logic             clr_r, clr_nxt, clr_now;
  logic [TOP_K-1:0] ge, valid_vec;
  logic             accept, active, ins;
  tas_entry_t       new_entry;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign active   = count_r < CNT_MAX;
  assign ins      = active && (in_class_prob != '0);

  assign new_entry.valid = 1'b1;
  assign new_entry.prob  = in_class_prob;
  assign new_entry.idx   = count_r[IDX_W-1:0];

  assign count_inc = active ? count_r + CNT_W'(1) : count_r;
  assign clr_now   = (count_r == '0) ? in_clear_totals : clr_r;

  // Sorted descending; ties keep the earlier (lower index) entry ahead.
  always_comb begin
    for (int j = 0; j < TOP_K; j++) begin
      ge[j]        = list_r[j].valid && (list_r[j].prob >= in_class_prob);
      valid_vec[j] = list_r[j].valid;
    end
    list_ins[0] = (!ins || ge[0]) ? list_r[0] : new_entry;
    for (int j = 1; j < TOP_K; j++) begin
      if (!ins || ge[j]) begin
        list_ins[j] = list_r[j];
      end else if (ge[j-1]) begin
        list_ins[j] = new_entry;
      end else begin
        list_ins[j] = list_r[j-1];
      end
    end
  end

  always_comb begin
    list_nxt   = list_r;
    count_nxt  = count_r;
    clr_nxt    = clr_r;
    push_valid = 1'b0;
    push_data.list  = list_ins;
    push_data.count = count_inc;
    push_data.label = in_true_label;
    push_data.clr   = clr_now;
    if (accept) begin
      if (in_class_last) begin
        // Hand the finished sample to the scorer and start fresh.
        push_valid = 1'b1;
        list_nxt   = '0;
        count_nxt  = '0;
        clr_nxt    = 1'b0;
      end else begin
        list_nxt  = list_ins;
        count_nxt = count_inc;
        clr_nxt   = clr_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_r  <= '0;
      count_r <= '0;
      clr_r   <= 1'b0;
    end else begin
      list_r  <= list_nxt;
      count_r <= count_nxt;
      clr_r   <= clr_nxt;
    end
  end

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + TOP_K'(1))) == '0)
    else $error("top list valid bits are not a prefix");

  a_empty_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (valid_vec == '0))
    else $error("top list holds entries before first class");

endmodule

`default_nettype wire

// ----- rtl/core/tas_queue.sv -----
`default_nettype none

module tas_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire tas_pkg::tas_sample_t push_data,
  output logic                      full,
  output logic                      not_empty,
  output tas_pkg::tas_sample_t      head_data,
  input  wire logic                 pop
);
  import tas_pkg::*;

  tas_sample_t        mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign not_empty = cnt_r != '0;
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("sample queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("sample queue read while empty");

endmodule

`default_nettype wire

// ----- rtl/core/tas_back.sv -----
`default_nettype none

module tas_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tas_pkg::PROB_BITS-1:0]      cfg_prob_threshold,
  input  wire logic                               head_valid,
  input  wire tas_pkg::tas_sample_t               head_data,
  output logic                                    pop,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_top1_hit,
  output logic                                    out_top5_hit,
  output logic signed [tas_pkg::LABEL_W-1:0]      out_predicted_class,
  output logic [tas_pkg::TOTAL_W-1:0]             out_top1_total,
  output logic [tas_pkg::TOTAL_W-1:0]             out_top5_total
);
  import tas_pkg::*;

  logic [PROB_BITS-1:0]      thr_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      hit1_r, hit5_r;
  logic signed [LABEL_W-1:0] pred_r;
  logic [TOTAL_W-1:0]        tot1_r, tot1_nxt, tot5_r, tot5_nxt, base1, base5;

  logic                      load, hit1, hit5, label_reject;
  logic [PROB_BITS-1:0]      best_p;
  logic signed [LABEL_W-1:0] pred_raw, pred;
  logic [TOP_K-1:0]          slot_hit;

  assign cfg_ready = 1'b1;
  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign pop       = load;

  assign label_reject = head_data.label == LABEL_REJECT;
  assign best_p   = head_data.list[0].valid ? head_data.list[0].prob : '0;
  assign pred_raw = head_data.list[0].valid ?
                    LABEL_W'({1'b0, head_data.list[0].idx}) : '0;
  assign pred     = (head_data.count == CNT_BINARY && pred_raw == '0) ? LABEL_NEG : pred_raw;
  assign hit1     = (best_p >= thr_r) ? (pred == head_data.label) : label_reject;

  // All slots are checked in parallel, so any slot hit scores the sample.
  always_comb begin
    for (int k = 0; k < TOP_K; k++) begin
      if (!head_data.list[k].valid) begin
        slot_hit[k] = 1'b0;
      end else if (head_data.list[k].prob >= thr_r) begin
        slot_hit[k] = !head_data.label[LABEL_W-1] &&
                      (head_data.label[LABEL_W-2:0] == (LABEL_W-1)'(head_data.list[k].idx));
      end else begin
        slot_hit[k] = label_reject;
      end
    end
  end
  assign hit5 = |slot_hit;

  assign base1    = head_data.clr ? '0 : tot1_r;
  assign base5    = head_data.clr ? '0 : tot5_r;
  assign tot1_nxt = (hit1 && base1 != TOTAL_MAX) ? base1 + TOTAL_W'(1) : base1;
  assign tot5_nxt = (hit5 && base5 != TOTAL_MAX) ? base5 + TOTAL_W'(1) : base5;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESH_RESET;
      out_valid_r <= 1'b0;
      tot1_r      <= '0;
      tot5_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_prob_threshold;
      end
      out_valid_r <= out_valid_nxt;
      if (load) begin
        tot1_r <= tot1_nxt;
        tot5_r <= tot5_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit1_r <= hit1;
      hit5_r <= hit5;
      pred_r <= pred;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_top1_hit        = hit1_r;
  assign out_top5_hit        = hit5_r;
  assign out_predicted_class = pred_r;
  assign out_top1_total      = tot1_r;
  assign out_top5_total      = tot5_r;

endmodule

`default_nettype wire

// ----- rtl/core/top5_accuracy_scorer.sv -----
// Top-k accuracy scorer with reject threshold. Class probabilities (unsigned
// Q0.16) stream in one per clock while the input is not stalled, in class
// order; the item with class_last set closes the sample and produces one
// result carrying top-1/top-5 hits, the argmax class (0 reported as -1 for
// two-class samples) and saturating running hit totals. Throughput is one
// item per clock while not stalled, set by the front list update, which
// compares each probability against all five sorted slots combinationally.
// The transfer of the last item writes the sample into a two-entry queue;
// from there it is scored into the output register once that register is
// empty or its result is being taken. The input stalls only while that
// queue is full, i.e. when results back up behind a stalled output.
// Write prob_threshold only while no sample is in flight.
`default_nettype none

module top5_accuracy_scorer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tas_pkg::PROB_BITS-1:0]      cfg_prob_threshold,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [tas_pkg::PROB_BITS-1:0]      in_class_prob,
  input  wire logic                               in_class_last,
  input  wire logic signed [tas_pkg::LABEL_W-1:0] in_true_label,
  input  wire logic                               in_clear_totals,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_top1_hit,
  output logic                                    out_top5_hit,
  output logic signed [tas_pkg::LABEL_W-1:0]      out_predicted_class,
  output logic [tas_pkg::TOTAL_W-1:0]             out_top1_total,
  output logic [tas_pkg::TOTAL_W-1:0]             out_top5_total
);
  import tas_pkg::*;

  logic        push_valid, q_full, q_not_empty, pop;
  tas_sample_t push_data, head_data;

  tas_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_class_prob   (in_class_prob),
    .in_class_last   (in_class_last),
    .in_true_label   (in_true_label),
    .in_clear_totals (in_clear_totals),
    .push_valid      (push_valid),
    .push_data       (push_data),
    .q_full          (q_full)
  );

  tas_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_data (head_data),
    .pop       (pop)
  );

  tas_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_prob_threshold  (cfg_prob_threshold),
    .head_valid          (q_not_empty),
    .head_data           (head_data),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_top1_hit        (out_top1_hit),
    .out_top5_hit        (out_top5_hit),
    .out_predicted_class (out_predicted_class),
    .out_top1_total      (out_top1_total),
    .out_top5_total      (out_top5_total)
  );

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
module tb_top;

  localparam int LIMIT_CYCLES = 800000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 500;
  localparam int MAX_GAP      = 13;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic                              top1_hit;
    logic                              top5_hit;
    logic signed [tas_pkg::LABEL_W-1:0] predicted_class;
    logic [tas_pkg::TOTAL_W-1:0]       top1_total;
    logic [tas_pkg::TOTAL_W-1:0]       top5_total;
  } score_t;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [tas_pkg::PROB_BITS-1:0]      cfg_prob_threshold;
  logic                               in_valid;
  logic                               in_stall;
  logic [tas_pkg::PROB_BITS-1:0]      in_class_prob;
  logic                               in_class_last;
  logic signed [tas_pkg::LABEL_W-1:0] in_true_label;
  logic                               in_clear_totals;
  logic                               out_valid;
  logic                               out_stall;
  logic                               out_top1_hit;
  logic                               out_top5_hit;
  logic signed [tas_pkg::LABEL_W-1:0] out_predicted_class;
  logic [tas_pkg::TOTAL_W-1:0]        out_top1_total;
  logic [tas_pkg::TOTAL_W-1:0]        out_top5_total;

  // scorer shadow state
  logic [tas_pkg::PROB_BITS-1:0] rank_prob [tas_pkg::TOP_K];
  logic [tas_pkg::IDX_W-1:0]     rank_idx  [tas_pkg::TOP_K];
  logic                          rank_ok   [tas_pkg::TOP_K];
  logic [tas_pkg::CNT_W-1:0]     class_seen;
  logic [tas_pkg::TOTAL_W-1:0]   hits1_model;
  logic [tas_pkg::TOTAL_W-1:0]   hits5_model;
  logic [tas_pkg::PROB_BITS-1:0] thr_model;

  score_t                        pending_scores [$];
  logic [tas_pkg::PROB_BITS-1:0] sample_probs [$];

  int  err_count;
  int  items_sent;
  int  results_checked;
  int  thresholds_set;
  int  cycle_count;
  int  hold_cycles;
  bit  idle_en;

  top5_accuracy_scorer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_prob_threshold  (cfg_prob_threshold),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_class_prob       (in_class_prob),
    .in_class_last       (in_class_last),
    .in_true_label       (in_true_label),
    .in_clear_totals     (in_clear_totals),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_top1_hit        (out_top1_hit),
    .out_top5_hit        (out_top5_hit),
    .out_predicted_class (out_predicted_class),
    .out_top1_total      (out_top1_total),
    .out_top5_total      (out_top5_total)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d scores pending", $time, cycle_count,
               pending_scores.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Fold one class probability into the top-k list; score on the last class.
  task automatic score_item(input logic [tas_pkg::PROB_BITS-1:0] p, input logic last,
                            input logic signed [tas_pkg::LABEL_W-1:0] label, input logic clr,
                            output bit emit, output score_t res);
    int                                 pos;
    logic [tas_pkg::PROB_BITS-1:0]      best;
    logic signed [tas_pkg::LABEL_W-1:0] pred;
    logic                               h1;
    logic                               h5;
    emit = 1'b0;
    res  = '0;
    h1   = 1'b0;
    h5   = 1'b0;
    if (clr && class_seen == '0) begin
      hits1_model = '0;
      hits5_model = '0;
    end
    if (class_seen < tas_pkg::CNT_MAX) begin
      if (p != '0) begin
        pos = 0;
        while (pos < tas_pkg::TOP_K && rank_ok[pos] && rank_prob[pos] >= p) pos++;
        if (pos < tas_pkg::TOP_K) begin
          for (int j = tas_pkg::TOP_K - 1; j > pos; j--) begin
            rank_prob[j] = rank_prob[j-1];
            rank_idx[j]  = rank_idx[j-1];
            rank_ok[j]   = rank_ok[j-1];
          end
          rank_prob[pos] = p;
          rank_idx[pos]  = class_seen[tas_pkg::IDX_W-1:0];
          rank_ok[pos]   = 1'b1;
        end
      end
      class_seen++;
    end
    if (last) begin
      best = rank_ok[0] ? rank_prob[0] : '0;
      pred = rank_ok[0] ? {1'b0, rank_idx[0]} : '0;
      // two-class samples report class 0 as the binary negative
      if (class_seen == tas_pkg::CNT_BINARY && pred == '0) pred = tas_pkg::LABEL_NEG;
      if (best >= thr_model) h1 = (pred == label);
      else h1 = (label == tas_pkg::LABEL_REJECT);
      for (int k = 0; k < tas_pkg::TOP_K; k++) begin
        if (rank_ok[k] && !h5) begin
          if (rank_prob[k] >= thr_model) h5 = ({1'b0, rank_idx[k]} == label);
          else h5 = (label == tas_pkg::LABEL_REJECT);
        end
      end
      if (h1 && hits1_model != tas_pkg::TOTAL_MAX) hits1_model++;
      if (h5 && hits5_model != tas_pkg::TOTAL_MAX) hits5_model++;
      res.top1_hit        = h1;
      res.top5_hit        = h5;
      res.predicted_class = pred;
      res.top1_total      = hits1_model;
      res.top5_total      = hits5_model;
      emit = 1'b1;
      for (int k = 0; k < tas_pkg::TOP_K; k++) begin
        rank_prob[k] = '0;
        rank_idx[k]  = '0;
        rank_ok[k]   = 1'b0;
      end
      class_seen = '0;
    end
  endtask

  task automatic check_field(input string name, input logic signed [32:0] want,
                             input logic signed [32:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    score_t want;
    score_t fresh;
    bit     emit;
    if (rst_n === 1'b1) begin
      if (cfg_valid && cfg_ready === 1'b1) thr_model = cfg_prob_threshold;
      if (out_valid === 1'b1 && !out_stall) begin
        results_checked++;
        if (pending_scores.size() == 0) begin
          err_count++;
          $display("%0t: result transfer with no score pending", $time);
        end else begin
          want = pending_scores.pop_front();
          check_field("top1_hit", want.top1_hit, out_top1_hit);
          check_field("top5_hit", want.top5_hit, out_top5_hit);
          check_field("predicted_class", want.predicted_class, out_predicted_class);
          check_field("top1_total", want.top1_total, out_top1_total);
          check_field("top5_total", want.top5_total, out_top5_total);
        end
      end
      if (in_valid && in_stall === 1'b0) begin
        score_item(in_class_prob, in_class_last, in_true_label, in_clear_totals, emit, fresh);
        if (emit) pending_scores.insert(pending_scores.size(), fresh);
      end
    end
  end

  // Result side: stall a random count before each transfer, or a long hold on request.
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = idle_en ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  // Leaves valid high after the transfer; the next call or drain() moves it on.
  task automatic send_item(input logic [tas_pkg::PROB_BITS-1:0] p, input logic last,
                           input logic signed [tas_pkg::LABEL_W-1:0] label, input logic clr);
    int gap;
    gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_class_prob   <= p;
    in_class_last   <= last;
    in_true_label   <= label;
    in_clear_totals <= clr;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic send_sample(input logic signed [tas_pkg::LABEL_W-1:0] label,
                             input logic clr_first, input logic clr_later);
    int n;
    n = sample_probs.size();
    for (int i = 0; i < n; i++)
      send_item(sample_probs[i], i == n - 1, label,
                (i == 0) ? clr_first : (clr_later | ($urandom_range(0, 7) == 0)));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [tas_pkg::PROB_BITS-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_prob_threshold <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    thresholds_set++;
  endtask

  function automatic int pick_class_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 4) return $urandom_range(1, 2);
    if (r < 16) return $urandom_range(3, 10);
    if (r < 19) return $urandom_range(11, 40);
    return $urandom_range(41, 120);
  endfunction

  // Mix of zeros, full scale, ties and values around the threshold.
  task automatic send_random_sample(input int n);
    int                            r;
    int                            lab;
    int                            near;
    bit                            flat;
    logic [tas_pkg::PROB_BITS-1:0] v;
    sample_probs.delete();
    flat = ($urandom_range(0, 15) == 0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 7);
      if (flat) v = '0;
      else case (r)
        0: v = '0;
        1: v = '1;
        2: v = (i > 0) ? sample_probs[$urandom_range(0, i - 1)] : 16'($urandom);
        3: begin
          near = int'(thr_model) + int'($urandom_range(0, 2)) - 1;
          if (near < 0) near = 0;
          if (near > 65535) near = 65535;
          v = near[15:0];
        end
        default: v = 16'($urandom);
      endcase
      sample_probs.insert(sample_probs.size(), v);
    end
    r = $urandom_range(0, 9);
    case (r)
      5: lab = int'(tas_pkg::LABEL_NEG);
      6: lab = int'(tas_pkg::LABEL_REJECT);
      7: lab = int'($urandom_range(0, 1025)) - 2;
      8: lab = 0;
      9: lab = 1;
      default: lab = $urandom_range(0, n - 1);
    endcase
    send_sample(lab[tas_pkg::LABEL_W-1:0], $urandom_range(0, 15) == 0, 1'b0);
  endtask

  task automatic test_directed_cases();
    sample_probs = '{16'hFFFF};
    send_sample(11'sd0, 1'b1, 1'b0);
    sample_probs = '{16'd40000, 16'd10000};
    send_sample(tas_pkg::LABEL_NEG, 1'b0, 1'b0);
    sample_probs = '{16'd0, 16'd0};
    send_sample(tas_pkg::LABEL_NEG, 1'b0, 1'b0);
    // equal probabilities keep the lower class ahead
    sample_probs = '{16'd30000, 16'd50000, 16'd50000, 16'd0, 16'hFFFF, 16'd1};
    send_sample(11'sd2, 1'b0, 1'b0);
    // clear on a later item must not touch the totals
    sample_probs = '{16'd100, 16'd200, 16'd300};
    send_sample(tas_pkg::LABEL_REJECT, 1'b0, 1'b1);
    sample_probs = '{16'd32768, 16'd32767, 16'd0};
    send_sample(11'sd0, 1'b0, 1'b0);
    sample_probs = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7};
    send_sample(11'sd1023, 1'b1, 1'b0);
    drain();
  endtask

  task automatic test_class_overflow();
    sample_probs.delete();
    for (int i = 0; i < tas_pkg::MAX_CLASSES + 6; i++)
      sample_probs.insert(sample_probs.size(),
                          (i == 1023 || i == 1025) ? 16'hFFFF :
                                                     16'($urandom_range(0, 30000)));
    send_sample(11'sd1023, 1'b0, 1'b1);
    send_random_sample(3);
    drain();
  endtask

  task automatic test_threshold_extremes();
    logic [tas_pkg::PROB_BITS-1:0] levels [5];
    levels = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFE, tas_pkg::THRESH_RESET};
    for (int i = 0; i < 5; i++) begin
      write_threshold(levels[i]);
      repeat (6) send_random_sample(pick_class_count());
    end
    drain();
  endtask

  task automatic test_backpressure();
    bit saved;
    saved = idle_en;
    idle_en = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (40) send_random_sample(1);
    drain();
    idle_en = saved;
  endtask

  task automatic test_random_samples();
    int start;
    int next_cfg;
    start    = items_sent;
    next_cfg = 400;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) idle_en = !idle_en;
      if (items_sent - start >= next_cfg) begin
        case ($urandom_range(0, 3))
          0: write_threshold('0);
          1: write_threshold('1);
          default: write_threshold(16'($urandom));
        endcase
        next_cfg += 400;
      end
      send_random_sample(pick_class_count());
    end
    drain();
  endtask

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_valid          = 1'b0;
    cfg_prob_threshold = '0;
    in_valid           = 1'b0;
    in_class_prob      = '0;
    in_class_last      = 1'b0;
    in_true_label      = '0;
    in_clear_totals    = 1'b0;
    idle_en            = 1'b1;
    hold_cycles        = 0;
    for (int k = 0; k < tas_pkg::TOP_K; k++) begin
      rank_prob[k] = '0;
      rank_idx[k]  = '0;
      rank_ok[k]   = 1'b0;
    end
    class_seen  = '0;
    hits1_model = '0;
    hits5_model = '0;
    thr_model   = tas_pkg::THRESH_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_class_overflow();
    test_threshold_extremes();
    test_backpressure();
    test_random_samples();

    $display("tb_top: %0d items sent, %0d results checked, %0d threshold writes",
             items_sent, results_checked, thresholds_set);
    $display("tb_top: covered ties, two-class remap, reject labels, class overflow, stalls");
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tas_pkg.sv
rtl/core/tas_front.sv
rtl/core/tas_queue.sv
rtl/core/tas_back.sv
rtl/core/top5_accuracy_scorer.sv
sim/tb_top.sv
